FILE: hdl/asert_pkg.sv
// shared types, widths and constants of the asert difficulty step
`default_nettype none

package asert_pkg;

    // fixed field widths
    localparam int DIFF_W      = 64;
    localparam int INTERVAL_W  = 32;
    localparam int TARGET_W    = 16;
    localparam int HALF_LIFE_W = 20;
    localparam int CFG_W       = 20;
    localparam int POLY_BITS   = 16;
    localparam int FACTOR_W    = POLY_BITS + 1;
    localparam int SHIFT_W     = 9;

    // configuration register indexes
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_TARGET    = 1'b0;
    localparam cfg_index_t CFG_HALF_LIFE = 1'b1;

    // register defaults
    localparam logic [TARGET_W-1:0]    TARGET_RESET    = 16'd15;
    localparam logic [HALF_LIFE_W-1:0] HALF_LIFE_RESET = 20'd3600;

    // cubic fit of 2^x - 1 on [0, 1), Q.64 accumulation
    localparam logic [47:0] POLY_C1    = 48'd195766423245049;
    localparam logic [29:0] POLY_C2    = 30'd971821376;
    localparam logic [12:0] POLY_C3    = 13'd5127;
    localparam logic [63:0] POLY_ROUND = 64'h0000_8000_0000_0000;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'h1_0000;

    // scale shift, clamped to the range that still changes the result
    typedef logic signed [SHIFT_W-1:0] shift_t;
    localparam shift_t SHIFT_MAX = 9'sd64;
    localparam shift_t SHIFT_MIN = -9'sd128;

    // word from the exponent stage to the polynomial stage
    typedef struct packed {
        logic [DIFF_W-1:0]    cur;
        logic [POLY_BITS-1:0] x;
        shift_t               shift;
    } expo_t;

    // word from the polynomial stage to the scale stage
    typedef struct packed {
        logic [DIFF_W-1:0]   cur;
        logic [FACTOR_W-1:0] factor;
        shift_t              shift;
    } scale_t;

endpackage

`default_nettype wire

FILE: hdl/asert_difficulty_step.sv
// top level of the asert difficulty step: configuration registers and pipeline
//
// channel  dir  handshake              word
// cfg      in   cfg_we                 cfg_index, cfg_data
// in       in   in_valid / in_stall    current_difficulty, block_interval
// out      out  out_valid / out_stall  next_difficulty, clamped_low, saturated_high
//
// one word per cycle while out_stall is low
// the exponent divider sets the pipeline depth and retires four quotient bits per stage
// reset clears all stage valid bits and loads target 15 and half life 3600
// a stalled output word holds while empty stages behind it keep filling,
// so in_stall rises only once every stage holds a word
`default_nettype none

module asert_difficulty_step
    import asert_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  cfg_index_t                   cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [DIFF_W-1:0]            current_difficulty,
    input  logic signed [INTERVAL_W-1:0] block_interval,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [DIFF_W-1:0]            next_difficulty,
    output logic                         clamped_low,
    output logic                         saturated_high
);

    logic [TARGET_W-1:0]    target_reg;
    logic [HALF_LIFE_W-1:0] half_life_reg;
    logic                   div_in_ready;
    logic                   div_out_valid;
    logic                   pow_in_ready;
    logic                   pow_out_valid;
    logic                   scale_in_ready;
    expo_t                  expo_word;
    scale_t                 scale_word;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_RESET;
            half_life_reg <= HALF_LIFE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET:
                begin
                    target_reg <= cfg_data[TARGET_W-1:0];
                end
                CFG_HALF_LIFE:
                begin
                    half_life_reg <= cfg_data[HALF_LIFE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // exponent from drift and half life
    asert_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .target    (target_reg),
        .half_life (half_life_reg),
        .in_valid  (in_valid),
        .in_ready  (div_in_ready),
        .cur_in    (current_difficulty),
        .interval  (block_interval),
        .out_valid (div_out_valid),
        .out_ready (pow_in_ready),
        .out_word  (expo_word)
    );

    // fractional power of two
    asert_pow2 u_pow2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_out_valid),
        .in_ready  (pow_in_ready),
        .in_word   (expo_word),
        .out_valid (pow_out_valid),
        .out_ready (scale_in_ready),
        .out_word  (scale_word)
    );

    // scale, shift and limit
    asert_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (pow_out_valid),
        .in_ready        (scale_in_ready),
        .in_word         (scale_word),
        .out_valid       (out_valid),
        .out_ready       (!out_stall),
        .next_difficulty (next_difficulty),
        .clamped_low     (clamped_low),
        .saturated_high  (saturated_high)
    );

    assign in_stall = !div_in_ready;

`ifndef NO_ASSERTIONS
    // a word never carries both flags
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(clamped_low && saturated_high))
        else $error("both limit flags set");

    // results never fall below one
    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (next_difficulty >= (DIFF_W'(1) << FRAC_BITS)))
        else $error("result below one");

    // saturation shows as all ones
    a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated_high) |-> (next_difficulty == '1))
        else $error("saturated result not all ones");

    // the front stalls only behind a waiting output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with output free");
`endif

endmodule

`default_nettype wire

FILE: hdl/asert_div.sv
// drift, pipelined floor division by the half life, and exponent split
`default_nettype none

module asert_div
    import asert_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [TARGET_W-1:0]           target,
    input  logic [HALF_LIFE_W-1:0]        half_life,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [DIFF_W-1:0]             cur_in,
    input  logic signed [INTERVAL_W-1:0]  interval,
    output logic                          out_valid,
    input  logic                          out_ready,
    output expo_t                         out_word
);

    localparam int MAG_W     = INTERVAL_W;
    localparam int DRIFT_W   = MAG_W + 2;
    localparam int NUM_W     = MAG_W + FRAC_BITS;
    localparam int STEP_BITS = 4;
    localparam int NUM_STEPS = (NUM_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W     = NUM_STEPS * STEP_BITS;
    localparam int E_W       = PAD_W + 1;
    localparam int IP_W      = E_W - FRAC_BITS;
    localparam int S_W       = IP_W + 1;
    localparam int LAST      = NUM_STEPS + 1;

    localparam logic signed [S_W-1:0] S_POLY = S_W'(POLY_BITS);
    localparam logic signed [S_W-1:0] S_HI   = S_W'(SHIFT_MAX);
    localparam logic signed [S_W-1:0] S_LO   = S_W'(SHIFT_MIN);

    typedef struct packed {
        logic [DIFF_W-1:0]      cur;
        logic                   neg;
        logic [PAD_W-1:0]       qn;
        logic [HALF_LIFE_W-1:0] rem;
    } work_t;

    // four restoring steps; numerator bits leave the top, quotient bits enter the bottom
    function automatic work_t div_steps(input work_t w, input logic [HALF_LIFE_W-1:0] d);
        work_t                r;
        logic [HALF_LIFE_W:0] part;
        r = w;
        for (int j = 0; j < STEP_BITS; j++)
        begin
            part = {r.rem, r.qn[PAD_W-1]};
            r.qn = {r.qn[PAD_W-2:0], 1'b0};
            if (part >= {1'b0, d})
            begin
                r.rem   = HALF_LIFE_W'(part - {1'b0, d});
                r.qn[0] = 1'b1;
            end
            else
            begin
                r.rem = part[HALF_LIFE_W-1:0];
            end
        end
        return r;
    endfunction

    logic [LAST:0]          vld_reg;
    logic [LAST+1:0]        ready;
    work_t                  work_reg  [NUM_STEPS+1];
    work_t                  work_next [NUM_STEPS+1];
    expo_t                  expo_reg;
    expo_t                  expo_next;
    logic [HALF_LIFE_W-1:0] divisor;
    logic [DRIFT_W-1:0]     drift;
    logic [DRIFT_W-1:0]     drift_mag;

    logic [PAD_W-1:0]                 quo;
    logic                             rem_nz;
    logic [E_W-1:0]                   e_val;
    logic signed [IP_W-1:0]           ipart;
    logic signed [S_W-1:0]            s_val;
    logic [FRAC_BITS-1:0]             frac;
    logic [FRAC_BITS+POLY_BITS-1:0]   frac_wide;

    // a zero half life divides by one
    assign divisor = (half_life == '0) ? HALF_LIFE_W'(1) : half_life;

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        ready[LAST+1] = out_ready;
        for (int k = LAST; k >= 0; k--)
        begin
            ready[k] = !vld_reg[k] || ready[k+1];
        end
    end

    // drift magnitude and sign, then the divide stages
    always_comb
    begin
        drift = {{(DRIFT_W-TARGET_W){1'b0}}, target}
              - {{(DRIFT_W-INTERVAL_W){interval[INTERVAL_W-1]}}, interval};
        drift_mag = drift[DRIFT_W-1] ? (~drift + DRIFT_W'(1)) : drift;
        work_next[0].cur = cur_in;
        work_next[0].neg = drift[DRIFT_W-1];
        work_next[0].qn  = PAD_W'({drift_mag[MAG_W-1:0], {FRAC_BITS{1'b0}}});
        work_next[0].rem = '0;
        for (int k = 1; k <= NUM_STEPS; k++)
        begin
            work_next[k] = div_steps(work_reg[k-1], divisor);
        end
    end

    // floor quotient, split into fraction and clamped shift
    always_comb
    begin
        quo    = work_reg[NUM_STEPS].qn;
        rem_nz = work_reg[NUM_STEPS].rem != '0;
        if (work_reg[NUM_STEPS].neg)
        begin
            e_val = E_W'(0) - (E_W'(quo) + E_W'(rem_nz));
        end
        else
        begin
            e_val = E_W'(quo);
        end
        frac      = e_val[FRAC_BITS-1:0];
        ipart     = $signed(e_val[E_W-1:FRAC_BITS]);
        s_val     = S_W'(ipart) - S_POLY;
        frac_wide = {frac, {POLY_BITS{1'b0}}} >> FRAC_BITS;
        expo_next.cur = work_reg[NUM_STEPS].cur;
        expo_next.x   = frac_wide[POLY_BITS-1:0];
        if (s_val > S_HI)
        begin
            expo_next.shift = SHIFT_MAX;
        end
        else if (s_val < S_LO)
        begin
            expo_next.shift = SHIFT_MIN;
        end
        else
        begin
            expo_next.shift = SHIFT_W'(s_val);
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k <= LAST; k++)
            begin
                if (ready[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= NUM_STEPS; k++)
        begin
            if (ready[k])
            begin
                work_reg[k] <= work_next[k];
            end
        end
        if (ready[LAST])
        begin
            expo_reg <= expo_next;
        end
    end

    assign in_ready  = ready[0];
    assign out_valid = vld_reg[LAST];
    assign out_word  = expo_reg;

endmodule

`default_nettype wire

FILE: hdl/asert_pow2.sv
// pipelined cubic polynomial for the fractional power of two
`default_nettype none

module asert_pow2
    import asert_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  expo_t  in_word,
    output logic   out_valid,
    input  logic   out_ready,
    output scale_t out_word
);

    localparam int NUM_ST = 4;

    typedef struct packed {
        logic [DIFF_W-1:0]    cur;
        shift_t               shift;
        logic [POLY_BITS-1:0] x;
        logic [31:0]          x2;
        logic [63:0]          t1;
    } st1_t;

    typedef struct packed {
        logic [DIFF_W-1:0] cur;
        shift_t            shift;
        logic [63:0]       t1;
        logic [63:0]       t2;
        logic [47:0]       x3;
    } st2_t;

    typedef struct packed {
        logic [DIFF_W-1:0] cur;
        shift_t            shift;
        logic [63:0]       t1;
        logic [63:0]       t2;
        logic [63:0]       t3;
    } st3_t;

    logic [NUM_ST-1:0] vld_reg;
    logic [NUM_ST:0]   ready;
    st1_t              st1_reg, st1_next;
    st2_t              st2_reg, st2_next;
    st3_t              st3_reg, st3_next;
    scale_t            st4_reg, st4_next;
    logic [63:0]       acc;

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        ready[NUM_ST] = out_ready;
        for (int k = NUM_ST - 1; k >= 0; k--)
        begin
            ready[k] = !vld_reg[k] || ready[k+1];
        end
    end

    // square and linear term
    always_comb
    begin
        st1_next.cur   = in_word.cur;
        st1_next.shift = in_word.shift;
        st1_next.x     = in_word.x;
        st1_next.x2    = 32'(in_word.x) * 32'(in_word.x);
        st1_next.t1    = 64'(POLY_C1) * 64'(in_word.x);
    end

    // cube and square term
    always_comb
    begin
        st2_next.cur   = st1_reg.cur;
        st2_next.shift = st1_reg.shift;
        st2_next.t1    = st1_reg.t1;
        st2_next.t2    = 64'(POLY_C2) * 64'(st1_reg.x2);
        st2_next.x3    = 48'(st1_reg.x2) * 48'(st1_reg.x);
    end

    // cubic term
    always_comb
    begin
        st3_next.cur   = st2_reg.cur;
        st3_next.shift = st2_reg.shift;
        st3_next.t1    = st2_reg.t1;
        st3_next.t2    = st2_reg.t2;
        st3_next.t3    = 64'(POLY_C3) * 64'(st2_reg.x3);
    end

    // sum with rounding, keep the top sixteen bits
    always_comb
    begin
        acc = st3_reg.t1 + st3_reg.t2 + st3_reg.t3 + POLY_ROUND;
        st4_next.cur    = st3_reg.cur;
        st4_next.shift  = st3_reg.shift;
        st4_next.factor = FACTOR_ONE + FACTOR_W'(acc[63:64-POLY_BITS]);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_ST; k++)
            begin
                if (ready[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            st1_reg <= st1_next;
        end
        if (ready[1])
        begin
            st2_reg <= st2_next;
        end
        if (ready[2])
        begin
            st3_reg <= st3_next;
        end
        if (ready[3])
        begin
            st4_reg <= st4_next;
        end
    end

    assign in_ready  = ready[0];
    assign out_valid = vld_reg[NUM_ST-1];
    assign out_word  = st4_reg;

endmodule

`default_nettype wire

FILE: hdl/asert_scale.sv
// difficulty times factor, power-of-two shift, saturation and floor
`default_nettype none

module asert_scale
    import asert_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  scale_t            in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DIFF_W-1:0] next_difficulty,
    output logic              clamped_low,
    output logic              saturated_high
);

    localparam int NUM_ST = 4;
    localparam int HALF_W = DIFF_W / 2;
    localparam int MUL_W  = HALF_W + FACTOR_W;
    localparam int PROD_W = DIFF_W + FACTOR_W;
    localparam int WIDE_W = PROD_W + 64;
    localparam logic [DIFF_W-1:0] ONE_VALUE = DIFF_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
        shift_t           shift;
    } mul_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        shift_t            shift;
    } prod_t;

    typedef struct packed {
        logic [DIFF_W-1:0] res;
        logic              sat;
    } shifted_t;

    typedef struct packed {
        logic [DIFF_W-1:0] res;
        logic              low;
        logic              sat;
    } result_t;

    logic [NUM_ST-1:0]  vld_reg;
    logic [NUM_ST:0]    ready;
    mul_t               mul_reg, mul_next;
    prod_t              prod_reg, prod_next;
    shifted_t           shf_reg, shf_next;
    result_t            res_reg, res_next;
    logic [WIDE_W-1:0]  wide;
    logic [SHIFT_W-1:0] neg_shift;

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        ready[NUM_ST] = out_ready;
        for (int k = NUM_ST - 1; k >= 0; k--)
        begin
            ready[k] = !vld_reg[k] || ready[k+1];
        end
    end

    // two half-width partial products
    always_comb
    begin
        mul_next.a     = MUL_W'(in_word.cur[HALF_W-1:0]) * MUL_W'(in_word.factor);
        mul_next.b     = MUL_W'(in_word.cur[DIFF_W-1:HALF_W]) * MUL_W'(in_word.factor);
        mul_next.shift = in_word.shift;
    end

    // combine into the full product
    always_comb
    begin
        prod_next.prod  = PROD_W'(mul_reg.a) + (PROD_W'(mul_reg.b) << HALF_W);
        prod_next.shift = mul_reg.shift;
    end

    // shift by the integer exponent, anything above 64 bits overflows
    always_comb
    begin
        neg_shift = SHIFT_W'(0) - $unsigned(prod_reg.shift);
        if (!prod_reg.shift[SHIFT_W-1])
        begin
            wide = WIDE_W'(prod_reg.prod) << prod_reg.shift[6:0];
        end
        else
        begin
            wide = WIDE_W'(prod_reg.prod) >> neg_shift[7:0];
        end
        shf_next.res = wide[DIFF_W-1:0];
        shf_next.sat = |wide[WIDE_W-1:DIFF_W];
    end

    // saturate to all ones or raise to one
    always_comb
    begin
        res_next.sat = shf_reg.sat;
        res_next.low = 1'b0;
        res_next.res = shf_reg.res;
        if (shf_reg.sat)
        begin
            res_next.res = '1;
        end
        else if (shf_reg.res < ONE_VALUE)
        begin
            res_next.res = ONE_VALUE;
            res_next.low = 1'b1;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_ST; k++)
            begin
                if (ready[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            mul_reg <= mul_next;
        end
        if (ready[1])
        begin
            prod_reg <= prod_next;
        end
        if (ready[2])
        begin
            shf_reg <= shf_next;
        end
        if (ready[3])
        begin
            res_reg <= res_next;
        end
    end

    assign in_ready        = ready[0];
    assign out_valid       = vld_reg[NUM_ST-1];
    assign next_difficulty = res_reg.res;
    assign clamped_low     = res_reg.low;
    assign saturated_high  = res_reg.sat;

endmodule

`default_nettype wire

FILE: verif/tb.sv
// self-checking testbench for asert_difficulty_step: directed table, then random words
`default_nettype none

module tb
    import asert_pkg::*;
();

    localparam int FRAC_BITS    = 16;
    localparam int LATENCY      = 22;
    localparam int STUCK_LIMIT  = 4000;
    localparam int CFG_SETS     = 12;
    localparam int WORDS_PER_SET = 160;

    localparam logic [DIFF_W-1:0] ALL_ONES  = '1;
    localparam logic [DIFF_W-1:0] ONE_FIXED = 64'h1_0000;

    // cubic fit of 2^x - 1, accumulated in Q.64 with wrap at 64 bits
    localparam longint unsigned CUBIC_A1   = 64'd195766423245049;
    localparam longint unsigned CUBIC_A2   = 64'd971821376;
    localparam longint unsigned CUBIC_A3   = 64'd5127;
    localparam longint unsigned CUBIC_HALF = 64'h0000_8000_0000_0000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [DIFF_W-1:0] diff;
        logic              low;
        logic              sat;
    } step_result_t;

    typedef struct packed {
        logic [DIFF_W-1:0]     cur;
        logic [INTERVAL_W-1:0] iv;
        logic                  known;
        step_result_t          want;
    } directed_row_t;

    // directed words under the reset registers (target 15, half life 3600)
    localparam directed_row_t DIRECTED_ROWS [22] = '{
        '{64'h0, 32'd15, 1'b1, '{64'h1_0000, 1'b1, 1'b0}},
        '{64'h5_0000, 32'd15, 1'b1, '{64'h5_0000, 1'b0, 1'b0}},
        '{ALL_ONES, 32'd15, 1'b1, '{ALL_ONES, 1'b0, 1'b0}},
        '{64'h1, 32'd15, 1'b1, '{64'h1_0000, 1'b1, 1'b0}},
        '{ALL_ONES, 32'h8000_0000, 1'b1, '{ALL_ONES, 1'b0, 1'b1}},
        '{ALL_ONES, 32'h7FFF_FFFF, 1'b1, '{64'h1_0000, 1'b1, 1'b0}},
        '{64'h0, 32'h8000_0000, 1'b1, '{64'h1_0000, 1'b1, 1'b0}},
        '{64'h3_0000, 32'hFFFF_F1FF, 1'b1, '{64'h6_0000, 1'b0, 1'b0}},
        '{64'h4_0000, 32'd3615, 1'b1, '{64'h2_0000, 1'b0, 1'b0}},
        '{ALL_ONES, 32'hFFFF_F1FF, 1'b1, '{ALL_ONES, 1'b0, 1'b1}},
        '{64'h1_0000, 32'd3615, 1'b1, '{64'h1_0000, 1'b1, 1'b0}},
        '{64'h8000_0000_0000_0000, 32'hFFFF_F1FF, 1'b1, '{ALL_ONES, 1'b0, 1'b1}},
        '{64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_F1FF, 1'b1,
          '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0}},
        '{64'h1_FFFF, 32'd3615, 1'b1, '{64'h1_0000, 1'b1, 1'b0}},
        '{64'h1_0000, 32'd0, 1'b0, '0},
        '{64'h1_0000, 32'd16, 1'b0, '0},
        '{64'h1_0000, 32'd14, 1'b0, '0},
        '{64'h1_0000, 32'hFFFF_FFFF, 1'b0, '0},
        '{64'h1_0000_0000, 32'hFFFF_F907, 1'b0, '0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 1'b0, '0},
        '{64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
        '{64'h0000_0000_FFFF_FFFF, 32'd1000, 1'b0, '0}
    };

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    cfg_index_t                   cfg_index = CFG_TARGET;
    logic [CFG_W-1:0]             cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [DIFF_W-1:0]            current_difficulty = '0;
    logic signed [INTERVAL_W-1:0] block_interval = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [DIFF_W-1:0]            next_difficulty;
    logic                         clamped_low;
    logic                         saturated_high;

    // predictor copy of the registers
    logic [TARGET_W-1:0]    target_q = 16'd15;
    logic [HALF_LIFE_W-1:0] half_life_q = 20'd3600;

    step_result_t due_results [$];
    idle_mode_t   idle_mode = IDLE_NONE;
    int           mismatches = 0;
    int           checked_words = 0;
    int           clamp_count = 0;
    int           sat_count = 0;
    int           stuck_cycles = 0;

    asert_difficulty_step dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .current_difficulty (current_difficulty),
        .block_interval     (block_interval),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .next_difficulty    (next_difficulty),
        .clamped_low        (clamped_low),
        .saturated_high     (saturated_high)
    );

    always #1 clk = ~clk;

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // next difficulty from the present one and the block time, under the current registers
    function automatic step_result_t adjust_difficulty(input logic [DIFF_W-1:0] cur,
                                                       input logic signed [INTERVAL_W-1:0] iv);
        longint          drift;
        longint          num;
        longint          e;
        longint          ipart;
        longint          sh;
        longint unsigned d;
        longint unsigned frac;
        longint unsigned acc;
        logic [127:0]    prod;
        logic [127:0]    moved;
        step_result_t    r;
        drift = longint'(target_q) - longint'(iv);
        num = drift <<< FRAC_BITS;
        d = (half_life_q == '0) ? 64'd1 : 64'(half_life_q);
        // floor division keeps the fraction in [0, 1)
        if (num >= 0)
            e = longint'($unsigned(num) / d);
        else
            e = -longint'(($unsigned(-num) + d - 64'd1) / d);
        frac = $unsigned(e) & ((64'd1 << FRAC_BITS) - 64'd1);
        ipart = (e - longint'(frac)) >>> FRAC_BITS;
        acc = CUBIC_A1 * frac + CUBIC_A2 * frac * frac + CUBIC_A3 * frac * frac * frac
              + CUBIC_HALF;
        prod = 128'(cur) * 128'(64'd65536 + (acc >> 48));
        sh = ipart - 16;
        r = '0;
        if (sh >= 0)
        begin
            if (prod == '0)
                r.diff = '0;
            else if (sh >= 64 || prod[127:64] != '0)
                r.sat = 1'b1;
            else
            begin
                moved = prod << sh;
                if (moved[127:64] != '0)
                    r.sat = 1'b1;
                else
                    r.diff = moved[63:0];
            end
        end
        else if (sh > -128)
        begin
            moved = prod >> (-sh);
            if (moved[127:64] != '0)
                r.sat = 1'b1;
            else
                r.diff = moved[63:0];
        end
        // saturate high, floor at 1.0
        if (r.sat)
            r.diff = ALL_ONES;
        else if (r.diff < ONE_FIXED)
        begin
            r.diff = ONE_FIXED;
            r.low = 1'b1;
        end
        return r;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 72;
            IDLE_BOTH:   return $urandom_range(0, 99) < 24;
            default:     return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // offer one word, queue its expected result once accepted
    task automatic send_step(input logic [DIFF_W-1:0] cur, input logic [INTERVAL_W-1:0] iv,
                             input logic known, input step_result_t want);
        if (sender_idles())
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (sender_idles());
        end
        in_valid <= 1'b1;
        current_difficulty <= cur;
        block_interval <= iv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        due_results.push_back(known ? want : adjust_difficulty(cur, iv));
    endtask

    // register writes, only while the pipeline is empty
    task automatic load_registers(input logic [TARGET_W-1:0] tgt,
                                  input logic [HALF_LIFE_W-1:0] hl);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TARGET;
        cfg_data <= {4'($urandom), tgt};
        @(posedge clk);
        cfg_index <= CFG_HALF_LIFE;
        cfg_data <= hl;
        @(posedge clk);
        cfg_we <= 1'b0;
        target_q = tgt;
        half_life_q = hl;
    endtask

    // receiver: random stall and result check
    always @(posedge clk)
    begin : receive
        step_result_t want;
        if (rst_n)
        begin
            case (idle_mode)
                IDLE_RECEIVER: out_stall <= ($urandom_range(0, 99) < 72);
                IDLE_BOTH:     out_stall <= ($urandom_range(0, 99) < 24);
                default:       out_stall <= 1'b0;
            endcase
            if (out_valid && !out_stall)
            begin
                checked_words++;
                clamp_count += clamped_low;
                sat_count += saturated_high;
                if (due_results.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", next_difficulty));
                else
                begin
                    want = due_results.pop_front();
                    if (next_difficulty !== want.diff)
                        report_mismatch($sformatf("next_difficulty %h, want %h",
                                                  next_difficulty, want.diff));
                    if (clamped_low !== want.low)
                        report_mismatch($sformatf("clamped_low %b, want %b",
                                                  clamped_low, want.low));
                    if (saturated_high !== want.sat)
                        report_mismatch($sformatf("saturated_high %b, want %b",
                                                  saturated_high, want.sat));
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int                    phase;
        int                    k;
        int                    pick;
        logic [TARGET_W-1:0]    tgt;
        logic [HALF_LIFE_W-1:0] hl;
        logic [DIFF_W-1:0]     cur;
        logic [INTERVAL_W-1:0] iv;
        longint                span;
        longint                delta;
        while (!rst_n) @(posedge clk);
        @(posedge clk);

        // directed table under the reset registers
        for (k = 0; k < $size(DIRECTED_ROWS); k++)
            send_step(DIRECTED_ROWS[k].cur, DIRECTED_ROWS[k].iv, DIRECTED_ROWS[k].known,
                      DIRECTED_ROWS[k].want);

        for (phase = 0; phase < CFG_SETS; phase++)
        begin
            in_valid <= 1'b0;
            while (due_results.size() != 0) @(posedge clk);
            // fixed settings first (reset values, extremes and one typical pair), then random register values
            case (phase)
                0:
                begin
                    tgt = 16'd15;
                    hl  = 20'd3600;
                end
                1:
                begin
                    tgt = 16'd0;
                    hl  = 20'd0;
                end
                2:
                begin
                    tgt = '1;
                    hl  = '1;
                end
                3:
                begin
                    tgt = 16'd1;
                    hl  = 20'd1;
                end
                4:
                begin
                    tgt = '1;
                    hl  = 20'd1;
                end
                5:
                begin
                    tgt = 16'd0;
                    hl  = '1;
                end
                6:
                begin
                    tgt = 16'd600;
                    hl  = 20'd86400;
                end
                default:
                begin
                    tgt = 16'($urandom);
                    hl  = 20'($urandom);
                end
            endcase
            load_registers(tgt, hl);
            idle_mode <= idle_mode_t'(phase % 4);
            span = (hl == '0) ? 64'sd1 : longint'(hl);

            for (k = 0; k < WORDS_PER_SET; k++)
            begin
                // block time: mostly within seventy half lives of the target
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    delta = longint'($urandom_range(0, 32'(140 * span))) - 70 * span;
                    iv = 32'(longint'(tgt) - delta);
                end
                else if (pick < 75)
                    iv = 32'(longint'(tgt) + longint'($urandom_range(0, 16)) - 8);
                else if (pick < 90)
                    iv = $urandom;
                else
                    case ($urandom_range(0, 3))
                        0: iv = 32'h8000_0000;
                        1: iv = 32'h7FFF_FFFF;
                        2: iv = 32'h0;
                        default: iv = 32'hFFFF_FFFF;
                    endcase
                // difficulty: spread over all magnitudes, some near the floor and the top
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    cur = {$urandom, $urandom} >> $urandom_range(0, 63);
                else if (pick < 88)
                    cur = ONE_FIXED + 64'($urandom_range(0, 2)) - 64'd1;
                else if (pick < 94)
                    cur = ALL_ONES;
                else
                    cur = '0;
                send_step(cur, iv, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        $display("checked %0d words: directed table, then %0d register settings under four idle",
                 checked_words, CFG_SETS);
        $display("patterns; %0d raised to 1.0, %0d saturated, %0d mismatches, %0d still due",
                 clamp_count, sat_count, mismatches, due_results.size());
        if (mismatches == 0 && due_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

FILE: asert_difficulty_step.f
hdl/asert_pkg.sv
hdl/asert_div.sv
hdl/asert_pow2.sv
hdl/asert_scale.sv
hdl/asert_difficulty_step.sv
verif/tb.sv
